### rtl/mpdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_pkg
// Types and codes shared by the presentation deadline clock and its users.
// ----------------------------------------------------------------------------
package mpdc_pkg;

    // Operation codes carried in each request.
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_PAUSE  = 3'd1;
    localparam logic [2:0] OP_RESUME = 3'd2;
    localparam logic [2:0] OP_SEEK   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_EVAL   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_READY_AHEAD   = 2'd0;
    localparam logic [1:0] CFG_READY_BEHIND  = 2'd1;
    localparam logic [1:0] CFG_SEVERE_BEHIND = 2'd2;

    localparam logic [30:0] READY_AHEAD_RST   = 31'd10000;
    localparam logic [30:0] READY_BEHIND_RST  = 31'd10000;
    localparam logic [30:0] SEVERE_BEHIND_RST = 31'd50000;

    // Deadline classes.
    localparam logic [1:0] CLASS_EARLY  = 2'd0;
    localparam logic [1:0] CLASS_READY  = 2'd1;
    localparam logic [1:0] CLASS_LATE   = 2'd2;
    localparam logic [1:0] CLASS_SEVERE = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic [63:0]        now_us;
        logic signed [63:0] pts_us;
        logic               ref_frame;
        logic               key_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] media_time_us;
        logic signed [63:0] pts_lead_us;
        logic [1:0]         deadline_class;
        logic               drop_frame;
        logic [31:0]        dropped_total;
        logic               clock_running;
        logic               clock_paused;
    } t_out_item;

endpackage

### rtl/media_presentation_deadline_clock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// media_presentation_deadline_clock_top
// Pausable media clock that classifies frame timestamps against media time.
//
// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_ready   i_in_item  (t_in_item)
// out       source     o_out_valid / i_out_ready o_out_item (t_out_item)
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle is sustained while the output is not stalled; each
// result passes from the input register through the clock stage, then
// through the classify stage, into the output register.
// The clock state is updated in the first stage, so a request sees the state
// left by the one before it. The drop counter lives in the classify stage.
// Each stage holds its contents while the one after it is full and stalled.
// Reset is synchronous, active low, and restores the default thresholds.
// ----------------------------------------------------------------------------
module media_presentation_deadline_clock_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mpdc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mpdc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [30:0]          i_cfg_data
);
    import mpdc_pkg::*;

    typedef struct packed {
        logic signed [63:0] media_time_us;
        logic signed [63:0] pts_us;
        logic               is_eval;
        logic               droppable;
        logic               clock_running;
        logic               clock_paused;
    } t_mid;

    // Configuration.
    logic [30:0] r_ready_ahead;
    logic [30:0] r_ready_behind;
    logic [30:0] r_severe_behind;

    // Clock state.
    logic        r_running;
    logic        r_paused;
    logic [63:0] r_start;
    logic [63:0] r_base;
    logic [63:0] r_paused_at;
    logic [31:0] r_drop_count;

    logic        n_running;
    logic        n_paused;
    logic [63:0] n_start;
    logic [63:0] n_base;
    logic [63:0] n_paused_at;
    logic [31:0] n_drop_count;

    // Pipeline registers.
    logic      r_in_v;
    t_in_item  r_in;
    logic      r_mid_v;
    t_mid      r_mid;
    logic      r_out_v;
    t_out_item r_out;

    t_mid      n_mid;
    t_out_item n_out;

    logic out_free;
    logic mid_free;
    logic in_go;
    logic mid_go;

    assign out_free   = !r_out_v || i_out_ready;
    assign mid_free   = !r_mid_v || out_free;
    assign in_go      = r_in_v && mid_free;
    assign mid_go     = r_mid_v && out_free;
    assign o_in_ready = !r_in_v || mid_free;
    assign o_cfg_ready = 1'b1;

    // ---------------- clock stage ----------------
    logic [63:0] e_now;
    logic [63:0] e_pa;
    logic [63:0] elapsed;
    logic        pause_act;
    logic        resume_act;
    logic        now_after_pa;

    assign e_now        = r_in.now_us - r_start;
    assign e_pa         = r_paused_at - r_start;
    assign now_after_pa = r_in.now_us > r_paused_at;
    assign pause_act    = (r_in.operation == OP_PAUSE) && r_running && !r_paused;
    assign resume_act   = (r_in.operation == OP_RESUME) && r_running && r_paused;

    always_comb begin
        n_running   = r_running;
        n_paused    = r_paused;
        n_start     = r_start;
        n_base      = r_base;
        n_paused_at = r_paused_at;
        elapsed     = e_now;

        unique case (r_in.operation)
            OP_START: begin
                n_start   = r_in.now_us;
                n_base    = r_in.pts_us;
                n_paused  = 1'b0;
                n_running = 1'b1;
            end
            OP_PAUSE: begin
                if (pause_act) begin
                    n_paused_at = r_in.now_us;
                    n_paused    = 1'b1;
                end
            end
            OP_RESUME: begin
                if (resume_act) begin
                    if (now_after_pa) begin
                        n_start = r_start + (r_in.now_us - r_paused_at);
                    end
                    n_paused = 1'b0;
                end
            end
            OP_SEEK: begin
                n_start     = r_in.now_us;
                n_base      = r_in.pts_us;
                n_paused_at = r_in.now_us;
            end
            default: begin
            end
        endcase

        n_mid.pts_us        = r_in.pts_us;
        n_mid.is_eval       = (r_in.operation == OP_EVAL);
        n_mid.droppable     = !r_in.ref_frame && !r_in.key_frame;
        n_mid.clock_running = n_running;
        n_mid.clock_paused  = n_paused;

        // After a late resume the elapsed time from the moved start equals the
        // span up to the pause, so no chained subtraction is needed.
        priority if (!n_running) begin
            n_mid.media_time_us = '0;
        end else if ((r_in.operation == OP_START) || (r_in.operation == OP_SEEK)) begin
            n_mid.media_time_us = r_in.pts_us;
        end else if (n_paused) begin
            n_mid.media_time_us = (pause_act ? e_now : e_pa) + r_base;
        end else begin
            if (resume_act && now_after_pa) begin
                elapsed = e_pa;
            end
            if (elapsed[63]) begin
                elapsed = '0;
            end
            n_mid.media_time_us = elapsed + r_base;
        end
    end

    // ---------------- classify stage ----------------
    logic signed [63:0] delta;
    logic signed [63:0] ahead_lim;
    logic signed [63:0] behind_lim;
    logic signed [63:0] severe_lim;
    logic               drop;

    assign delta      = r_mid.pts_us - r_mid.media_time_us;
    assign ahead_lim  = $signed({33'd0, r_ready_ahead});
    assign behind_lim = -$signed({33'd0, r_ready_behind});
    assign severe_lim = -$signed({33'd0, r_severe_behind});
    assign drop       = r_mid.is_eval && r_mid.droppable && (delta < severe_lim);

    always_comb begin
        n_drop_count          = drop ? r_drop_count + 32'd1 : r_drop_count;
        n_out.media_time_us   = r_mid.media_time_us;
        n_out.pts_lead_us     = '0;
        n_out.deadline_class  = CLASS_EARLY;
        n_out.drop_frame      = drop;
        n_out.dropped_total   = n_drop_count;
        n_out.clock_running   = r_mid.clock_running;
        n_out.clock_paused    = r_mid.clock_paused;
        if (r_mid.is_eval) begin
            n_out.pts_lead_us = delta;
            priority if (delta > ahead_lim) begin
                n_out.deadline_class = CLASS_EARLY;
            end else if (delta >= behind_lim) begin
                n_out.deadline_class = CLASS_READY;
            end else if (delta >= severe_lim) begin
                n_out.deadline_class = CLASS_LATE;
            end else begin
                n_out.deadline_class = CLASS_SEVERE;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v          <= 1'b0;
            r_mid_v         <= 1'b0;
            r_out_v         <= 1'b0;
            r_running       <= 1'b0;
            r_paused        <= 1'b0;
            r_start         <= '0;
            r_base          <= '0;
            r_paused_at     <= '0;
            r_drop_count    <= '0;
            r_ready_ahead   <= READY_AHEAD_RST;
            r_ready_behind  <= READY_BEHIND_RST;
            r_severe_behind <= SEVERE_BEHIND_RST;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_READY_AHEAD:   r_ready_ahead   <= i_cfg_data;
                    CFG_READY_BEHIND:  r_ready_behind  <= i_cfg_data;
                    CFG_SEVERE_BEHIND: r_severe_behind <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && o_in_ready) begin
                r_in_v <= 1'b1;
            end else if (in_go) begin
                r_in_v <= 1'b0;
            end

            if (in_go) begin
                r_mid_v     <= 1'b1;
                r_running   <= n_running;
                r_paused    <= n_paused;
                r_start     <= n_start;
                r_base      <= n_base;
                r_paused_at <= n_paused_at;
            end else if (mid_go) begin
                r_mid_v <= 1'b0;
            end

            if (mid_go) begin
                r_out_v      <= 1'b1;
                r_drop_count <= n_drop_count;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (in_go) begin
            r_mid <= n_mid;
        end
        if (mid_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule
